>>> hw/rtl/concatenate_and_sort_ascending_macros.svh
// Assertion macros shared by the checker of the ascending sorter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CONCATENATE_AND_SORT_ASCENDING_MACROS_SVH
`define CONCATENATE_AND_SORT_ASCENDING_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define CAS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after an antecedent.
`define CAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/cas_pkg.sv
// Shared types and constants of the ascending sorter.
// Depends on nothing; imported by cas_front, cas_back, the top level and the checker.
package cas_pkg;

	localparam int DATA_W           = 32;
	localparam int MAX_ELEMENTS_DEF = 32;
	localparam int MID_DEPTH        = 4;
	localparam int OUT_DEPTH        = 4;
	localparam int OUT_CNT_W        = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     is_final;
		logic                     keep;
		logic                     ovf;
	} mid_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     end_of_run;
		logic                     dropped;
	} out_beat_t;

endpackage

>>> hw/rtl/cas_fifo.sv
// Small first-in first-out queue with a fill count.
// Depends on nothing; used between the stages and at the result side of the sorter.
module cas_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign dout    = slots_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> hw/rtl/cas_front.sv
// Input side of the sorter: accepts elements and decides whether each one fits.
// Depends on cas_pkg; feeds the queue in front of cas_back.
module cas_front import cas_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     is_final,
	input  logic                     mid_full,
	output logic                     mid_push,
	output mid_beat_t                mid_beat
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             keep;

	assign full              = mid_full;
	assign mid_push          = push && !mid_full;
	assign keep              = (cnt_q < CNT_W'(MAX_ELEMENTS));
	assign mid_beat.value    = value;
	assign mid_beat.is_final = is_final;
	assign mid_beat.keep     = keep;
	assign mid_beat.ovf      = ovf_q || !keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (mid_push) begin
			if (is_final) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(keep);
				ovf_q <= ovf_q || !keep;
			end
		end
	end

endmodule

>>> hw/rtl/cas_back.sv
// Work side of the sorter: loads the element store, bubble sorts it in place
// and reads it out in order. Depends on cas_pkg; drains the middle queue.
module cas_back import cas_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mid_beat_t            mid_beat,
	input  logic                 mid_empty,
	output logic                 mid_pop,
	input  logic [OUT_CNT_W-1:0] out_count,
	output logic                 out_push,
	output out_beat_t            out_beat
);

	localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_TAIL,
		ST_EMIT
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;
	logic [CNT_W-1:0]         rd_idx_q;
	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         rd_pos_s1;
	logic signed [DATA_W-1:0] rd_data_s1;
	logic signed [DATA_W-1:0] carry_q;
	logic                     swapped_q;
	logic signed [DATA_W-1:0] mem_q [MAX_ELEMENTS];

	logic [CNT_W-1:0]         cnt_m1;
	logic [CNT_W-1:0]         load_total;
	logic [OUT_CNT_W:0]       out_used;
	logic                     room;
	logic                     more;
	logic                     rd_en;
	logic [IDX_W-1:0]         rd_addr;
	logic                     last_pos;
	logic                     greater;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic signed [DATA_W-1:0] wr_data;

	assign mid_pop    = (state_q == ST_LOAD) && !mid_empty;
	assign load_total = cnt_q + CNT_W'(mid_beat.keep);
	assign cnt_m1     = cnt_q - 1'b1;
	assign out_used   = {1'b0, out_count} + (OUT_CNT_W + 1)'(rd_vld_s1);
	assign room       = (out_used < (OUT_CNT_W + 1)'(OUT_DEPTH));
	assign more       = (rd_idx_q < cnt_q);
	assign rd_en      = more && ((state_q == ST_SORT) || ((state_q == ST_EMIT) && room));
	assign rd_addr    = rd_idx_q[IDX_W-1:0];
	assign last_pos   = (CNT_W'(rd_pos_s1) == cnt_m1);
	assign greater    = (carry_q > rd_data_s1);

	assign out_push              = (state_q == ST_EMIT) && rd_vld_s1;
	assign out_beat.sorted_value = rd_data_s1;
	assign out_beat.end_of_run   = last_pos;
	assign out_beat.dropped      = ovf_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[IDX_W-1:0];
		wr_data = mid_beat.value;
		case (state_q)
			ST_LOAD: begin
				wr_en = mid_pop && mid_beat.keep;
			end
			ST_SORT: begin
				wr_en   = rd_vld_s1 && (rd_pos_s1 != '0);
				wr_addr = rd_pos_s1 - 1'b1;
				wr_data = greater ? rd_data_s1 : carry_q;
			end
			ST_TAIL: begin
				wr_en   = 1'b1;
				wr_addr = cnt_m1[IDX_W-1:0];
				wr_data = carry_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			rd_pos_s1 <= '0;
			carry_q   <= '0;
			swapped_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			rd_pos_s1 <= rd_addr;
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			case (state_q)
				ST_LOAD: begin
					if (mid_pop) begin
						cnt_q <= load_total;
						if (mid_beat.is_final) begin
							ovf_q     <= mid_beat.ovf;
							rd_idx_q  <= '0;
							swapped_q <= 1'b0;
							state_q   <= (load_total > CNT_W'(1)) ? ST_SORT : ST_EMIT;
						end
					end
				end
				ST_SORT: begin
					if (rd_vld_s1) begin
						if (rd_pos_s1 == '0) begin
							carry_q <= rd_data_s1;
						end else if (greater) begin
							swapped_q <= 1'b1;
						end else begin
							carry_q <= rd_data_s1;
						end
						if (last_pos) begin
							state_q <= ST_TAIL;
						end
					end
				end
				ST_TAIL: begin
					rd_idx_q <= '0;
					if (swapped_q) begin
						swapped_q <= 1'b0;
						state_q   <= ST_SORT;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (rd_vld_s1 && last_pos) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/concatenate_and_sort_ascending.sv
// Ascending sorter top level. Depends on cas_pkg, cas_front, cas_fifo and cas_back.
// Elements are written into the element store from the middle queue. On the final
// element the store of n values is bubble sorted in place, one compare per cycle
// through one read and one write port of the element store, in up to n passes;
// after the last pass the results follow at one per cycle while pop keeps up.
// Elements beyond MAX_ELEMENTS are discarded and every result of that set carries
// dropped.
module concatenate_and_sort_ascending import cas_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     is_final,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic                     end_of_run,
	output logic                     dropped
);

	mid_beat_t            mid_in;
	mid_beat_t            mid_out;
	logic                 mid_push;
	logic                 mid_full;
	logic                 mid_pop;
	logic                 mid_empty;
	out_beat_t            out_in;
	out_beat_t            out_head;
	logic                 out_push;
	logic [OUT_CNT_W-1:0] out_count;

	cas_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.value   (value),
		.is_final(is_final),
		.mid_full(mid_full),
		.mid_push(mid_push),
		.mid_beat(mid_in)
	);

	cas_fifo #(
		.WIDTH($bits(mid_beat_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (mid_push),
		.din   (mid_in),
		.full  (mid_full),
		.pop   (mid_pop),
		.dout  (mid_out),
		.empty (mid_empty),
		.count ()
	);

	cas_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.mid_beat (mid_out),
		.mid_empty(mid_empty),
		.mid_pop  (mid_pop),
		.out_count(out_count),
		.out_push (out_push),
		.out_beat (out_in)
	);

	cas_fifo #(
		.WIDTH($bits(out_beat_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.din   (out_in),
		.full  (),
		.pop   (pop),
		.dout  (out_head),
		.empty (empty),
		.count (out_count)
	);

	assign sorted_value = out_head.sorted_value;
	assign end_of_run   = out_head.end_of_run;
	assign dropped      = out_head.dropped;

endmodule

>>> hw/rtl/cas_checker.sv
// Port-level checker of the ascending sorter and its bind to the top level.
// Depends on cas_pkg and concatenate_and_sort_ascending_macros.svh.
`include "concatenate_and_sort_ascending_macros.svh"

module cas_checker import cas_pkg::*; #(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     empty,
	input logic                     pop,
	input logic signed [DATA_W-1:0] sorted_value,
	input logic                     end_of_run,
	input logic                     dropped
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	logic                     beat_taken;
	logic                     mid_run_q;
	logic [CNT_W-1:0]         run_len_q;
	logic signed [DATA_W-1:0] last_value_q;
	logic                     last_dropped_q;

	assign beat_taken = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_run_q <= 1'b0;
			run_len_q <= '0;
		end else if (beat_taken) begin
			mid_run_q <= !end_of_run;
			run_len_q <= end_of_run ? '0 : run_len_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_taken) begin
			last_value_q   <= sorted_value;
			last_dropped_q <= dropped;
		end
	end

	`CAS_ASSERT_NEXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(sorted_value) && $stable(end_of_run) && $stable(dropped), "result beat changed while stalled")
	`CAS_ASSERT_ALWAYS(a_ascending, clk, arst_n, !(beat_taken && mid_run_q) || (sorted_value >= last_value_q), "results of a run are not ascending")
	`CAS_ASSERT_ALWAYS(a_dropped_steady, clk, arst_n, !(beat_taken && mid_run_q) || (dropped == last_dropped_q), "dropped flag changed within a run")
	`CAS_ASSERT_ALWAYS(a_run_bounded, clk, arst_n, !beat_taken || (run_len_q < CNT_W'(MAX_ELEMENTS)), "run longer than the element store")

endmodule

bind concatenate_and_sort_ascending cas_checker #(
	.MAX_ELEMENTS(MAX_ELEMENTS)
) u_cas_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.sorted_value(sorted_value),
	.end_of_run  (end_of_run),
	.dropped     (dropped)
);
